>>> rtl/core/shbs_pkg.sv
package shbs_pkg;

    // Sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } shbs_state_t;

    typedef logic [7:0][31:0] shbs_vars_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // Initial hash values
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/core/shbs_round.sv
module shbs_round
    import shbs_pkg::*;
(
    input  shbs_vars_t  v_in,
    input  logic [31:0] k,
    input  logic [31:0] w0,
    input  logic [31:0] w1,
    input  logic [31:0] w9,
    input  logic [31:0] w14,
    output shbs_vars_t  v_out,
    output logic [31:0] w_new
);

    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] t1;
    logic [31:0] s0;
    logic [31:0] s1;

    // One compression round, a is v_in[0]
    always_comb
    begin
        big1   = rotr(v_in[4], 6) ^ rotr(v_in[4], 11) ^ rotr(v_in[4], 25);
        choose = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
        t1     = v_in[7] + big1 + choose + k + w0;
        big0   = rotr(v_in[0], 2) ^ rotr(v_in[0], 13) ^ rotr(v_in[0], 22);
        major  = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + big0 + major;
    end

    // Message schedule word sixteen places ahead
    always_comb
    begin
        s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
    end

endmodule

>>> rtl/core/sha256_byte_stream_hasher_unit.sv
// SHA-256 hasher fed one byte per beat.
// Input channel: in_valid / in_stall with kind and data_byte. kind 0 absorbs
// data_byte; kind 1 closes the message, pads it and produces the digest.
// Output channel: out_valid / out_stall with four beats per digest, most
// significant first: digest_word, word_index 0..3, last_word on the fourth.
// Flow: the 64th byte of a block starts the compression, 64 rounds of the
// shared round unit and then a step to fold the result into the hash; the
// input stalls for the whole compression. A finish with f bytes buffered
// pushes 64 - f pad bytes, one a cycle, then compresses and then drives the
// digest; when f is 56 or more the length does not fit and a second block of
// 64 pad bytes follows (two final blocks).
// The digest sits in an output buffer, so new message bytes are taken while
// it drains; a following finish is taken, but its digest waits with the
// input stalled until the buffer is empty.
// When out_stall is high the current digest beat holds unchanged.
// Reset (rst_n low) returns the hash to its initial values, empties the
// buffer count and drops any pending digest.
module sha256_byte_stream_hasher_unit
    import shbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    shbs_state_t state_reg, state_next;
    logic [31:0]  hash_reg [8];
    logic [31:0]  hash_next [8];
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [5:0]   round_reg, round_next;
    logic         finish_reg, finish_next;
    logic         sent80_reg, sent80_next;
    logic         len_reg, len_next;
    logic [511:0] blk_reg, blk_next;
    shbs_vars_t   v_reg, v_next;
    logic         ovalid_reg, ovalid_next;
    logic [1:0]   oidx_reg, oidx_next;
    logic [255:0] obuf_reg, obuf_next;

    logic         push;
    logic [7:0]   push_byte;
    logic         obuf_load;
    logic [5:0]   len_sel;
    shbs_vars_t   v_round;
    logic [31:0]  w_new;

    // Shared round unit; schedule taps come from the block shift line
    shbs_round u_round
    (
        .v_in  (v_reg),
        .k     (ROUND_K[round_reg]),
        .w0    (blk_reg[511:480]),
        .w1    (blk_reg[479:448]),
        .w9    (blk_reg[223:192]),
        .w14   (blk_reg[63:32]),
        .v_out (v_round),
        .w_new (w_new)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign len_sel  = {3'(3'd7 - fill_reg[2:0]), 3'b000};

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        round_next  = round_reg;
        finish_next = finish_reg;
        sent80_next = sent80_reg;
        len_next    = len_reg;
        blk_next    = blk_reg;
        v_next      = v_reg;
        hash_next   = hash_reg;
        push        = 1'b0;
        push_byte   = '0;
        obuf_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!kind)
                    begin
                        push      = 1'b1;
                        push_byte = data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    else
                    begin
                        finish_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                if (!sent80_reg)
                begin
                    push_byte   = PAD_MARK;
                    sent80_next = 1'b1;
                end
                else if (len_reg || fill_reg == LEN_START)
                begin
                    push_byte = bits_reg[len_sel +: 8];
                    len_next  = 1'b1;
                end
            end
            ST_ROUND:
            begin
                v_next     = v_round;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                if (len_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (finish_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg)
                begin
                    obuf_load   = 1'b1;
                    hash_next   = INIT_HASH;
                    bits_next   = '0;
                    finish_next = 1'b0;
                    sent80_next = 1'b0;
                    len_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte into the block; a full block starts the rounds
        if (push)
        begin
            blk_next  = {blk_reg[503:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_BYTE)
            begin
                state_next = ST_ROUND;
                round_next = '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_next[i] = hash_reg[i];
                end
            end
        end
    end

    // Digest output buffer, one 64-bit word a beat
    always_comb
    begin
        ovalid_next = ovalid_reg;
        oidx_next   = oidx_reg;
        obuf_next   = obuf_reg;
        if (obuf_load)
        begin
            ovalid_next = 1'b1;
            oidx_next   = '0;
            for (int i = 0; i < 8; i++)
            begin
                obuf_next[255 - 32 * i -: 32] = hash_reg[i];
            end
        end
        else if (ovalid_reg && !out_stall)
        begin
            obuf_next = {obuf_reg[191:0], 64'd0};
            oidx_next = oidx_reg + 2'd1;
            if (oidx_reg == 2'd3)
            begin
                ovalid_next = 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign digest_word = obuf_reg[255:192];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 2'd3);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hash_reg   <= INIT_HASH;
            fill_reg   <= '0;
            bits_reg   <= '0;
            round_reg  <= '0;
            finish_reg <= 1'b0;
            sent80_reg <= 1'b0;
            len_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            round_reg  <= round_next;
            finish_reg <= finish_next;
            sent80_reg <= sent80_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
            oidx_reg   <= oidx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        v_reg    <= v_next;
        obuf_reg <= obuf_next;
    end

endmodule

>>> rtl/core/shbs_checker.sv
module shbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    // Stalled digest beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest beat changed while stalled");

    // Four digest words come back to back once taken
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=> out_valid)
        else $error("digest burst broken");

    // Word index steps by one within a digest
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=> word_index == $past(word_index) + 2'd1)
        else $error("digest word index out of order");

    // A data byte never starts a digest on its own
    a_no_digest: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !kind |=> !$rose(out_valid))
        else $error("digest started by a data byte");

endmodule

bind sha256_byte_stream_hasher_unit shbs_checker u_shbs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
